// File: design/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// shared constants, types and helpers of the tensor transpose streamer
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int MAX_RANK    = 4;
  localparam int DIM_BITS    = 10;
  localparam int DATA_WIDTH  = 32;
  localparam int NDIMS       = 4;
  localparam int SEL_W       = 2;
  localparam int PERM_W      = NDIMS * SEL_W;
  localparam int CFG_SIZE_W  = 11;
  localparam int SIZE_W      = DIM_BITS + 1;
  localparam int SIZE_CAP    = 1 << DIM_BITS;
  localparam int DEST_W      = 40;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int OUT_W       = ((DATA_WIDTH + DEST_W + 7) / 8) * 8;

  localparam logic [CFG_SIZE_W-1:0] SIZE_RESET = CFG_SIZE_W'(1);
  localparam logic [PERM_W-1:0]     PERM_RESET = PERM_W'(228);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM_SIZE_0  = 3'd0,
    CFG_DIM_SIZE_1  = 3'd1,
    CFG_DIM_SIZE_2  = 3'd2,
    CFG_DIM_SIZE_3  = 3'd3,
    CFG_PERMUTATION = 3'd4
  } cfg_idx_t;

  typedef logic [DIM_BITS-1:0] digit_t;
  typedef logic [SIZE_W-1:0]   dsize_t;

  typedef struct packed {
    dsize_t [NDIMS-1:0]  size;
    logic [PERM_W-1:0]   perm;
    logic                perm_invalid;
  } cfg_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] element;
    digit_t [NDIMS-1:0]    digit;
    logic                  last;
  } item_t;

  // effective size: clamp to 1..2^DIM_BITS, leading dims of lower ranks are 1
  function automatic dsize_t eff_size(input int unsigned d, input logic [CFG_SIZE_W-1:0] v);
    dsize_t r;
    if (d < NDIMS - MAX_RANK) begin
      r = SIZE_W'(1);
    end else if (v == '0) begin
      r = SIZE_W'(1);
    end else if (32'(v) > SIZE_CAP) begin
      r = SIZE_W'(SIZE_CAP);
    end else begin
      r = SIZE_W'(v);
    end
    return r;
  endfunction

  function automatic logic [SEL_W-1:0] perm_sel(input logic [PERM_W-1:0] p, input int unsigned d);
    return p[SEL_W*d +: SEL_W];
  endfunction

  function automatic logic perm_bad(input logic [PERM_W-1:0] p);
    logic [NDIMS-1:0] seen;
    seen = '0;
    for (int d = 0; d < NDIMS; d++) begin
      seen[perm_sel(p, d)] = 1'b1;
    end
    return seen != '1;
  endfunction

endpackage

// File: design/tensor_transpose_streamer.sv
// ----------------------------------------------------------------------------
// tensor_transpose_streamer
// streams a row-major tensor of up to four dims with transposed flat indices
// ----------------------------------------------------------------------------
// throughput: one element per cycle while out_tready accepts results,
// set by the 4-stage index pipeline and the two-entry queue behind the
// counter front end
// reset: sizes to 1, permutation to identity, counter and pipeline cleared
// ----------------------------------------------------------------------------
module tensor_transpose_streamer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tts_pkg::DATA_WIDTH-1:0]    in_tdata,   // element
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tts_pkg::OUT_W-1:0]         out_tdata,  // element_out, dest_index
  output logic                              out_tlast,
  output logic                              out_tuser,  // perm_invalid
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tts_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [tts_pkg::CFG_SIZE_W-1:0] size_r [tts_pkg::NDIMS];
  logic [tts_pkg::PERM_W-1:0]     perm_r;
  tts_pkg::cfg_t                  cfg;

  logic                           push;
  tts_pkg::item_t                 push_item;
  logic                           q_full;
  logic                           pop;
  logic                           q_not_empty;
  tts_pkg::item_t                 q_head;
  logic [tts_pkg::DATA_WIDTH-1:0] res_element;
  logic [tts_pkg::DEST_W-1:0]     res_dest;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < tts_pkg::NDIMS; d++) begin
        size_r[d] <= tts_pkg::SIZE_RESET;
      end
      perm_r <= tts_pkg::PERM_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        tts_pkg::CFG_DIM_SIZE_0: begin
          size_r[0] <= cfg_data[tts_pkg::CFG_SIZE_W-1:0];
        end
        tts_pkg::CFG_DIM_SIZE_1: begin
          size_r[1] <= cfg_data[tts_pkg::CFG_SIZE_W-1:0];
        end
        tts_pkg::CFG_DIM_SIZE_2: begin
          size_r[2] <= cfg_data[tts_pkg::CFG_SIZE_W-1:0];
        end
        tts_pkg::CFG_DIM_SIZE_3: begin
          size_r[3] <= cfg_data[tts_pkg::CFG_SIZE_W-1:0];
        end
        tts_pkg::CFG_PERMUTATION: begin
          perm_r <= cfg_data[tts_pkg::PERM_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int d = 0; d < tts_pkg::NDIMS; d++) begin
      cfg.size[d] = tts_pkg::eff_size(d, size_r[d]);
    end
    cfg.perm         = perm_r;
    cfg.perm_invalid = tts_pkg::perm_bad(perm_r);
  end

  tts_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_element (in_tdata),
    .cfg        (cfg),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item)
  );

  tts_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  tts_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .q_not_empty      (q_not_empty),
    .q_head           (q_head),
    .pop              (pop),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_element      (res_element),
    .out_dest         (res_dest),
    .out_last         (out_tlast),
    .out_perm_invalid (out_tuser)
  );

  assign out_tdata = tts_pkg::OUT_W'({res_dest, res_element});

endmodule

// File: design/tts_front.sv
// ----------------------------------------------------------------------------
// tts_front
// accepts source elements and tags each with its source counter and last mark
// ----------------------------------------------------------------------------
module tts_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tts_pkg::DATA_WIDTH-1:0]  in_element,
  input  tts_pkg::cfg_t                   cfg,
  input  logic                            q_full,
  output logic                            push,
  output tts_pkg::item_t                  push_item
);

  tts_pkg::digit_t [tts_pkg::NDIMS-1:0] cnt_r;
  tts_pkg::digit_t [tts_pkg::NDIMS-1:0] cnt_nxt;
  logic                                 carry;
  tts_pkg::dsize_t                      inc;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // odometer advance, innermost digit first
  always_comb begin
    carry = 1'b1;
    inc   = '0;
    for (int d = tts_pkg::NDIMS - 1; d >= 0; d--) begin
      inc = {1'b0, cnt_r[d]} + tts_pkg::SIZE_W'(1);
      if (!carry) begin
        cnt_nxt[d] = cnt_r[d];
      end else if (inc < cfg.size[d]) begin
        cnt_nxt[d] = inc[tts_pkg::DIM_BITS-1:0];
        carry      = 1'b0;
      end else begin
        cnt_nxt[d] = '0;
      end
    end
  end

  always_comb begin
    push_item.element = in_element;
    push_item.digit   = cnt_r;
    push_item.last    = carry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (push) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: design/tts_queue.sv
// ----------------------------------------------------------------------------
// tts_queue
// two-entry queue between the front and back parts
// ----------------------------------------------------------------------------
module tts_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tts_pkg::item_t  push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output tts_pkg::item_t  head
);

  localparam int DEPTH = 2;
  localparam int PTR_W = 1;
  localparam int CNT_W = 2;

  tts_pkg::item_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign full      = count_r == CNT_W'(DEPTH);
  assign not_empty = count_r != '0;
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

// File: design/tts_back.sv
// ----------------------------------------------------------------------------
// tts_back
// pipelined destination index computation and output register
// ----------------------------------------------------------------------------
module tts_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tts_pkg::cfg_t                   cfg,
  input  logic                            q_not_empty,
  input  tts_pkg::item_t                  q_head,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tts_pkg::DATA_WIDTH-1:0]  out_element,
  output logic [tts_pkg::DEST_W-1:0]      out_dest,
  output logic                            out_last,
  output logic                            out_perm_invalid
);

  localparam int DW    = tts_pkg::DIM_BITS;
  localparam int SW    = tts_pkg::SIZE_W;
  localparam int T2_W  = DW + SW;
  localparam int P23_W = 2 * SW;
  localparam int T1_W  = DW + P23_W;
  localparam int S01_W = P23_W + SW;
  localparam int DEW   = tts_pkg::DEST_W;
  localparam int DAW   = tts_pkg::DATA_WIDTH;

  logic                                 adv;
  tts_pkg::digit_t [tts_pkg::NDIMS-1:0] q;
  tts_pkg::dsize_t [tts_pkg::NDIMS-1:0] psz;

  // stage 1
  logic             v1_r;
  logic [DAW-1:0]   e1_r;
  logic             l1_r;
  tts_pkg::digit_t  q0_1_r, q1_1_r, q3_1_r;
  logic [T2_W-1:0]  t2_1_r;
  logic [P23_W-1:0] p23_1_r;
  tts_pkg::dsize_t  sz1_1_r;
  // stage 2
  logic             v2_r;
  logic [DAW-1:0]   e2_r;
  logic             l2_r;
  tts_pkg::digit_t  q0_2_r;
  logic [DEW-1:0]   a2_r;
  logic [T1_W-1:0]  t1_2_r;
  logic [S01_W-1:0] s01_2_r;
  // stage 3
  logic             v3_r;
  logic [DAW-1:0]   e3_r;
  logic             l3_r;
  logic [DEW-1:0]   b3_r;
  logic [DEW-1:0]   t0_3_r;
  // output register
  logic             vo_r;
  logic [DAW-1:0]   eo_r;
  logic             lo_r;
  logic [DEW-1:0]   do_r;
  logic             io_r;

  assign adv = !vo_r || out_ready;
  assign pop = adv && q_not_empty;

  // result dimension d reads source digit and size perm[d]
  always_comb begin
    for (int d = 0; d < tts_pkg::NDIMS; d++) begin
      q[d]   = q_head.digit[tts_pkg::perm_sel(cfg.perm, d)];
      psz[d] = cfg.size[tts_pkg::perm_sel(cfg.perm, d)];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_r    <= q_head.element;
      l1_r    <= q_head.last;
      q0_1_r  <= q[0];
      q1_1_r  <= q[1];
      q3_1_r  <= q[3];
      t2_1_r  <= T2_W'(q[2]) * T2_W'(psz[3]);
      p23_1_r <= P23_W'(psz[3]) * P23_W'(psz[2]);
      sz1_1_r <= psz[1];

      e2_r    <= e1_r;
      l2_r    <= l1_r;
      q0_2_r  <= q0_1_r;
      a2_r    <= DEW'(q3_1_r) + DEW'(t2_1_r);
      t1_2_r  <= T1_W'(q1_1_r) * T1_W'(p23_1_r);
      s01_2_r <= S01_W'(p23_1_r) * S01_W'(sz1_1_r);

      e3_r    <= e2_r;
      l3_r    <= l2_r;
      b3_r    <= a2_r + DEW'(t1_2_r);
      t0_3_r  <= DEW'(q0_2_r) * DEW'(s01_2_r);

      eo_r    <= e3_r;
      lo_r    <= l3_r;
      do_r    <= b3_r + t0_3_r;
      io_r    <= cfg.perm_invalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (adv) begin
      v1_r <= q_not_empty;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vo_r <= v3_r;
    end
  end

  assign out_valid        = vo_r;
  assign out_element      = eo_r;
  assign out_dest         = do_r;
  assign out_last         = lo_r;
  assign out_perm_invalid = io_r;

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks the tensor transpose streamer against an in-bench index predictor.
// each accepted element is run through a copy of the source counter and the
// permuted stride sum; results are matched in order, field by field, under
// random gaps on both streams, long receiver hold-offs and repeated
// reconfiguration between phases
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned TOTAL_ITEMS  = 1120;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES  = 300;

  typedef struct {
    logic [tts_pkg::DATA_WIDTH-1:0] element;
    logic [tts_pkg::DEST_W-1:0]     dest;
    logic                           last;
    logic                           bad_perm;
  } transposed_elem_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [tts_pkg::DATA_WIDTH-1:0] in_tdata;   // element
  logic                           out_tvalid;
  logic                           out_tready;
  logic [tts_pkg::OUT_W-1:0]      out_tdata;  // element_out, dest_index
  logic                           out_tlast;
  logic                           out_tuser;  // perm_invalid
  logic                           cfg_valid;
  logic                           cfg_ready;
  tts_pkg::cfg_idx_t              cfg_index;
  logic [tts_pkg::CFG_DATA_W-1:0] cfg_data;

  logic [tts_pkg::CFG_SIZE_W-1:0] cur_size [tts_pkg::NDIMS];
  logic [tts_pkg::PERM_W-1:0]     cur_perm;
  logic [tts_pkg::DIM_BITS-1:0]   ctr_digit [tts_pkg::NDIMS];
  transposed_elem_t               pending_results [$];

  int          err_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned sent_count;
  bit          tx_gaps_on;
  bit          rx_stalls_on;
  int unsigned rx_hold_req = 0;

  tensor_transpose_streamer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clamp_size(input int unsigned d,
                                             input logic [tts_pkg::CFG_SIZE_W-1:0] v);
    if (d < tts_pkg::NDIMS - tts_pkg::MAX_RANK) return 1;
    if (v == '0) return 1;
    if (int'(v) > (1 << tts_pkg::DIM_BITS)) return 1 << tts_pkg::DIM_BITS;
    return int'(v);
  endfunction

  // permuted stride sum of the current position, then odometer advance
  function automatic transposed_elem_t transpose_predict(
      input logic [tts_pkg::DATA_WIDTH-1:0] elem);
    transposed_elem_t              r;
    logic [63:0]                   stride;
    logic [63:0]                   dest;
    logic [tts_pkg::SEL_W-1:0]     s;
    logic [tts_pkg::NDIMS-1:0]     hit;
    logic [tts_pkg::DIM_BITS:0]    nxt;
    logic                          carry;
    stride = 64'd1;
    dest   = 64'd0;
    hit    = '0;
    for (int d = tts_pkg::NDIMS - 1; d >= 0; d--) begin
      s = cur_perm[tts_pkg::SEL_W*d +: tts_pkg::SEL_W];
      hit[s] = 1'b1;
      dest = dest + 64'(ctr_digit[s]) * stride;
      stride = stride * 64'(clamp_size(s, cur_size[s]));
    end
    carry = 1'b1;
    for (int d = tts_pkg::NDIMS - 1; d >= 0; d--) begin
      if (carry) begin
        nxt = {1'b0, ctr_digit[d]} + 1'b1;
        if (int'(nxt) < clamp_size(d, cur_size[d])) begin
          ctr_digit[d] = nxt[tts_pkg::DIM_BITS-1:0];
          carry = 1'b0;
        end else begin
          ctr_digit[d] = '0;
        end
      end
    end
    r.element  = elem;
    r.dest     = dest[tts_pkg::DEST_W-1:0];
    r.last     = carry;
    r.bad_perm = (hit != '1);
    return r;
  endfunction

  // tracks config, predicts accepted elements and checks results in order
  always @(posedge clk) begin
    transposed_elem_t want;
    if (!rst_n) begin
      for (int d = 0; d < tts_pkg::NDIMS; d++) begin
        cur_size[d]  = tts_pkg::SIZE_RESET;
        ctr_digit[d] = '0;
      end
      cur_perm = tts_pkg::PERM_RESET;
      pending_results.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        pending_results.insert(pending_results.size(), transpose_predict(in_tdata));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tts_pkg::CFG_DIM_SIZE_0:  cur_size[0] = cfg_data[tts_pkg::CFG_SIZE_W-1:0];
          tts_pkg::CFG_DIM_SIZE_1:  cur_size[1] = cfg_data[tts_pkg::CFG_SIZE_W-1:0];
          tts_pkg::CFG_DIM_SIZE_2:  cur_size[2] = cfg_data[tts_pkg::CFG_SIZE_W-1:0];
          tts_pkg::CFG_DIM_SIZE_3:  cur_size[3] = cfg_data[tts_pkg::CFG_SIZE_W-1:0];
          tts_pkg::CFG_PERMUTATION: cur_perm = cfg_data[tts_pkg::PERM_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with nothing expected: tdata %h", out_tdata);
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[tts_pkg::DATA_WIDTH-1:0] !== want.element) begin
            $error("element_out: expected %h, got %h", want.element,
                   out_tdata[tts_pkg::DATA_WIDTH-1:0]);
            err_cnt++;
          end
          if (out_tdata[tts_pkg::DATA_WIDTH +: tts_pkg::DEST_W] !== want.dest) begin
            $error("dest_index: expected %0d, got %0d", want.dest,
                   out_tdata[tts_pkg::DATA_WIDTH +: tts_pkg::DEST_W]);
            err_cnt++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_tlast);
            err_cnt++;
          end
          if (out_tuser !== want.bad_perm) begin
            $error("perm_invalid: expected %b, got %b", want.bad_perm, out_tuser);
            err_cnt++;
          end
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side backpressure
  initial begin
    int unsigned run_len;
    int unsigned hold_left;
    int unsigned hold_seen;
    out_tready = 1'b0;
    run_len    = 0;
    hold_left  = 0;
    hold_seen  = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req != hold_seen) begin
        hold_left = HOLD_CYCLES;
        hold_seen = rx_hold_req;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (!rx_stalls_on) begin
        out_tready <= 1'b1;
      end else if (run_len > 0) begin
        run_len--;
      end else if ($urandom_range(0, 99) < 70) begin
        out_tready <= 1'b1;
        run_len = $urandom_range(0, 15);
      end else begin
        out_tready <= 1'b0;
        run_len = pick_gap();
      end
    end
  end

  task automatic send_element(input logic [tts_pkg::DATA_WIDTH-1:0] elem);
    int unsigned gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= elem;
    do @(posedge clk); while (!in_tready);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    wait_drain();
  endtask

  task automatic load_config(input logic [tts_pkg::CFG_DATA_W-1:0] s0,
                             input logic [tts_pkg::CFG_DATA_W-1:0] s1,
                             input logic [tts_pkg::CFG_DATA_W-1:0] s2,
                             input logic [tts_pkg::CFG_DATA_W-1:0] s3,
                             input logic [tts_pkg::CFG_DATA_W-1:0] perm);
    logic [tts_pkg::CFG_DATA_W-1:0] vals [5];
    tts_pkg::cfg_idx_t              regs [5];
    vals = '{s0, s1, s2, s3, perm};
    regs = '{tts_pkg::CFG_DIM_SIZE_0, tts_pkg::CFG_DIM_SIZE_1, tts_pkg::CFG_DIM_SIZE_2,
             tts_pkg::CFG_DIM_SIZE_3, tts_pkg::CFG_PERMUTATION};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [tts_pkg::PERM_W-1:0] pick_perm();
    int unsigned                sel [tts_pkg::NDIMS];
    int unsigned                j;
    int unsigned                tmp;
    logic [tts_pkg::PERM_W-1:0] p;
    if ($urandom_range(0, 99) < 25) return tts_pkg::PERM_W'($urandom_range(0, 255));
    for (int d = 0; d < tts_pkg::NDIMS; d++) sel[d] = d;
    for (int d = tts_pkg::NDIMS - 1; d > 0; d--) begin
      j = $urandom_range(0, d);
      tmp = sel[d];
      sel[d] = sel[j];
      sel[j] = tmp;
    end
    for (int d = 0; d < tts_pkg::NDIMS; d++)
      p[tts_pkg::SEL_W*d +: tts_pkg::SEL_W] = tts_pkg::SEL_W'(sel[d]);
    return p;
  endfunction

  function automatic logic [tts_pkg::CFG_DATA_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return tts_pkg::CFG_DATA_W'($urandom_range(1, 4));
    if (r < 80) return tts_pkg::CFG_DATA_W'($urandom_range(5, 1024));
    if (r < 85) return '0;
    if (r < 90) return tts_pkg::CFG_DATA_W'(1024);
    if (r < 95) return tts_pkg::CFG_DATA_W'($urandom_range(1025, 2047));
    return tts_pkg::CFG_DATA_W'(1);
  endfunction

  // reset sizes are all one, so every element wraps the counter
  task automatic test_reset_state();
    send_element(32'h0000_0000);
    send_element(32'hFFFF_FFFF);
    send_element(32'hAAAA_AAAA);
    send_element(32'h5555_5555);
    settle();
  endtask

  // 2x3 inner block with the two inner dims swapped, plus one element past the wrap
  task automatic test_small_transpose();
    load_config(1, 1, 2, 3, 11'b000_10_11_01_00);
    for (int i = 0; i < 7; i++) send_element($urandom());
    settle();
  endtask

  // zero acts as one, oversized values clamp to the counter range
  task automatic test_size_clamp();
    load_config(0, 2047, 1025, 2, {3'b000, tts_pkg::PERM_RESET});
    for (int i = 0; i < 4; i++) send_element($urandom());
    settle();
  endtask

  // repeated selections, also with stray upper bits on the write data
  task automatic test_bad_permutation();
    load_config(1, 1, 2, 2, 11'h700);
    for (int i = 0; i < 3; i++) send_element($urandom());
    settle();
    load_config(2, 1, 3, 2, 11'h0FF);
    for (int i = 0; i < 3; i++) send_element($urandom());
    settle();
  endtask

  // receiver holds off long enough for the block to fill and stall the input
  task automatic test_backpressure();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b1;
    load_config(2, 3, 4, 5, {3'b000, pick_perm()});
    rx_hold_req++;
    for (int i = 0; i < 40; i++) send_element($urandom());
    settle();
    tx_gaps_on = 1'b1;
    for (int i = 0; i < 20; i++) send_element($urandom());
    settle();
  endtask

  // walks the innermost digit far up so later phases see large digits
  task automatic test_deep_counter();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    load_config(1, 1, 1, 1024, {3'b000, tts_pkg::PERM_RESET});
    for (int i = 0; i < 600; i++) send_element($urandom());
    settle();
  endtask

  // stale large digit under big strides reaches the top index bits
  task automatic test_high_index();
    load_config(1024, 1024, 1024, 1024, 11'b000_00_01_10_11);
    for (int i = 0; i < 12; i++) send_element($urandom());
    settle();
    load_config(1024, 1, 1, 1024, 11'h0FF);
    for (int i = 0; i < 12; i++) send_element($urandom());
    settle();
  endtask

  task automatic test_random_phases();
    logic [tts_pkg::CFG_DATA_W-1:0] sz [tts_pkg::NDIMS];
    logic [tts_pkg::PERM_W-1:0]     p;
    longint unsigned                vol;
    int unsigned                    n;
    while (sent_count < TOTAL_ITEMS) begin
      vol = 1;
      for (int d = 0; d < tts_pkg::NDIMS; d++) begin
        sz[d] = pick_size();
        vol = vol * clamp_size(d, sz[d][tts_pkg::CFG_SIZE_W-1:0]);
      end
      p = pick_perm();
      tx_gaps_on   = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      load_config(sz[0], sz[1], sz[2], sz[3], {3'($urandom_range(0, 7)), p});
      if (vol <= 48)
        n = int'(vol) * $urandom_range(1, 2) + $urandom_range(0, 3);
      else
        n = $urandom_range(1, 40);
      for (int i = 0; i < n; i++) send_element($urandom());
      settle();
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = tts_pkg::CFG_DIM_SIZE_0;
    cfg_data     = '0;
    sent_count   = 0;
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_state();
    test_small_transpose();
    test_size_clamp();
    test_bad_permutation();
    test_backpressure();
    test_deep_counter();
    test_high_index();
    test_random_phases();

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
